@@ sv/vcsh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel chunk store package
// Grid geometry, memory widths, command and neighbor step codes, and the
// shared address helpers.
// ----------------------------------------------------------------------------
package vcsh_pkg;

    // Grid geometry
    localparam int SIDE   = 16;
    localparam int HEIGHT = 16;
    localparam int CELLS  = SIDE * SIDE * HEIGHT;
    localparam int COLS   = SIDE * SIDE;
    localparam int TOP_Y  = HEIGHT - 1;
    localparam int EDGE   = SIDE - 1;

    // Field and memory widths
    localparam int COORD_W   = 4;
    localparam int ID_W      = 8;
    localparam int BORDER_W  = 4;
    localparam int MASK_W    = 6;
    localparam int OUT_HGT_W = 4;
    localparam int VOX_AW    = $clog2(CELLS);
    localparam int COL_AW    = $clog2(COLS);
    localparam int HW        = (HEIGHT > 2) ? $clog2(HEIGHT) : 1;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    // Cell reads of one query, in issue order; up..back map to mask bits 0..5
    typedef enum logic [2:0] {
        STEP_SELF  = 3'd0,
        STEP_UP    = 3'd1,
        STEP_DOWN  = 3'd2,
        STEP_LEFT  = 3'd3,
        STEP_RIGHT = 3'd4,
        STEP_FRONT = 3'd5,
        STEP_BACK  = 3'd6
    } step_t;

    typedef struct packed {
        logic              we;
        logic [VOX_AW-1:0] addr;
        logic [ID_W-1:0]   wdata;
    } vox_req_t;

    typedef struct packed {
        logic              we;
        logic [COL_AW-1:0] addr;
        logic [HW-1:0]     wdata;
    } hgt_req_t;

    typedef struct packed {
        logic [VOX_AW-1:0] addr;
        logic              forced;
        logic              fval;
    } nbr_t;

    function automatic logic [VOX_AW-1:0] cell_addr(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        return VOX_AW'((int'(x) * HEIGHT + int'(y)) * SIDE + int'(z));
    endfunction

    function automatic logic [COL_AW-1:0] col_addr(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] z
    );
        return COL_AW'(int'(x) * SIDE + int'(z));
    endfunction

endpackage
`default_nettype wire

@@ sv/vcsh_nbr_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Neighbor address unit
// Map a base position and a step code to the cell address to read, or to a
// fixed visibility bit where the neighbor lies at the grid edge.
// ----------------------------------------------------------------------------
module vcsh_nbr_unit (
    input  wire logic [vcsh_pkg::COORD_W-1:0]  x,
    input  wire logic [vcsh_pkg::COORD_W-1:0]  y,
    input  wire logic [vcsh_pkg::COORD_W-1:0]  z,
    input  wire logic [vcsh_pkg::BORDER_W-1:0] border,
    input  wire vcsh_pkg::step_t               step,
    output vcsh_pkg::nbr_t                     nbr
);

    logic [vcsh_pkg::COORD_W-1:0] nx;
    logic [vcsh_pkg::COORD_W-1:0] ny;
    logic [vcsh_pkg::COORD_W-1:0] nz;
    logic                         forced;
    logic                         fval;

    always_comb begin
        nx     = x;
        ny     = y;
        nz     = z;
        forced = 1'b0;
        fval   = 1'b0;
        case (step)
            vcsh_pkg::STEP_UP: begin
                ny     = y + 1'b1;
                forced = (int'(y) == vcsh_pkg::TOP_Y);
                fval   = 1'b1;
            end
            vcsh_pkg::STEP_DOWN: begin
                ny     = y - 1'b1;
                forced = (y == '0);
                fval   = 1'b1;
            end
            vcsh_pkg::STEP_LEFT: begin
                nx     = x - 1'b1;
                forced = (x == '0);
                fval   = border[0];
            end
            vcsh_pkg::STEP_RIGHT: begin
                nx     = x + 1'b1;
                forced = (int'(x) == vcsh_pkg::EDGE);
                fval   = border[1];
            end
            vcsh_pkg::STEP_FRONT: begin
                nz     = z - 1'b1;
                forced = (z == '0);
                fval   = border[2];
            end
            vcsh_pkg::STEP_BACK: begin
                nz     = z + 1'b1;
                forced = (int'(z) == vcsh_pkg::EDGE);
                fval   = border[3];
            end
            default: begin
                forced = 1'b0;
            end
        endcase
    end

    assign nbr.addr   = vcsh_pkg::cell_addr(nx, ny, nz);
    assign nbr.forced = forced;
    assign nbr.fval   = fval;

endmodule
`default_nettype wire

@@ sv/vcsh_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel and height stores
// Single-port block id memory and column height memory, each with a
// registered read port.
// ----------------------------------------------------------------------------
module vcsh_store (
    input  wire logic                     aclk,
    input  wire vcsh_pkg::vox_req_t       vox_req,
    output logic [vcsh_pkg::ID_W-1:0]     vox_rdata,
    input  wire vcsh_pkg::hgt_req_t       hgt_req,
    output logic [vcsh_pkg::HW-1:0]       hgt_rdata
);

    logic [vcsh_pkg::ID_W-1:0] vox_mem [vcsh_pkg::CELLS];
    logic [vcsh_pkg::HW-1:0]   hgt_mem [vcsh_pkg::COLS];

    always_ff @(posedge aclk) begin
        if (vox_req.we) begin
            vox_mem[vox_req.addr] <= vox_req.wdata;
        end
        vox_rdata <= vox_mem[vox_req.addr];
    end

    always_ff @(posedge aclk) begin
        if (hgt_req.we) begin
            hgt_mem[hgt_req.addr] <= hgt_req.wdata;
        end
        hgt_rdata <= hgt_mem[hgt_req.addr];
    end

endmodule
`default_nettype wire

@@ sv/voxel_chunk_store_heightmap_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel chunk store with column height map
// A 16x16x16 grid of 8-bit block ids (0 is air) with a per-column top height
// and a changed flag, answering every command with the view of one cell.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to air and zero height, one
// entry a cycle, while s_tready stays low. Then each command beat yields
// exactly one result beat. A query, a clear-flag command or a plain write
// reads the column height from the height memory, then makes the seven
// cell reads of the face test (one voxel memory read per cycle, pipelined
// through its registered read port), loads the output register and goes
// back to idle to take the next beat. Writing air at the recorded column
// top adds a downward scan of the column, which reads and checks one cell
// at a time until it finds a solid cell or reaches the floor. The single
// voxel memory port is why the cell reads go one at a time. A finished
// result waits in the output register; the next command is taken while it
// waits and only the final load step stalls on m_tready. cmd 3 answers as
// a query; cmd 2 drops the changed flag and answers as a query.
// ----------------------------------------------------------------------------
module voxel_chunk_store_heightmap_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Command channel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: pos_x[3:0], pos_y[7:4], pos_z[11:8], block_id[19:12],
    //        border_open[23:20]
    input  wire logic [vcsh_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: cmd[1:0]
    input  wire logic [1:0]                         s_tuser,
    // Result channel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata: cell_value[7:0], column_height[11:8], face_mask[17:12],
    //        changed[18], zero fill[23:19]
    output logic [vcsh_pkg::M_TDATA_W-1:0]          m_tdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,     // post-reset sweep of both memories
        ST_IDLE,      // wait for a command beat
        ST_HREAD,     // address the column height
        ST_HUSE,      // height ready: write the cell, update the height
        ST_SCAN_RD,   // address the next cell down the column
        ST_SCAN_USE,  // check that cell for air
        ST_FACE,      // stream the seven cell reads of the face test
        ST_DONE       // load the output register
    } state_t;

    localparam int FACE_LAST = 7;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                              state_reg,     state_next;
    logic [vcsh_pkg::VOX_AW-1:0]         clr_cnt_reg,   clr_cnt_next;
    vcsh_pkg::cmd_t                      cmd_reg,       cmd_next;
    logic [vcsh_pkg::COORD_W-1:0]        x_reg,         x_next;
    logic [vcsh_pkg::COORD_W-1:0]        y_reg,         y_next;
    logic [vcsh_pkg::COORD_W-1:0]        z_reg,         z_next;
    logic [vcsh_pkg::ID_W-1:0]           id_reg,        id_next;
    logic [vcsh_pkg::BORDER_W-1:0]       border_reg,    border_next;
    logic                                inside_reg,    inside_next;
    logic                                changed_reg,   changed_next;
    logic [vcsh_pkg::HW-1:0]             hgt_reg,       hgt_next;
    logic [vcsh_pkg::COORD_W-1:0]        t_reg,         t_next;
    logic [2:0]                          k_reg,         k_next;
    vcsh_pkg::step_t                     prev_step_reg, prev_step_next;
    logic                                prev_frc_reg,  prev_frc_next;
    logic                                prev_fval_reg, prev_fval_next;
    logic [vcsh_pkg::ID_W-1:0]           cell_reg,      cell_next;
    logic [vcsh_pkg::MASK_W-1:0]         mask_reg,      mask_next;
    logic                                m_tvalid_reg,  m_tvalid_next;
    logic [vcsh_pkg::M_TDATA_W-1:0]      m_tdata_reg,   m_tdata_next;

    // ------------------------------------------------------------------
    // Shared address unit and memories
    // ------------------------------------------------------------------
    logic [vcsh_pkg::COORD_W-1:0]        nbr_y;
    vcsh_pkg::step_t                     nbr_step;
    vcsh_pkg::nbr_t                      nbr;
    vcsh_pkg::vox_req_t                  vox_req;
    vcsh_pkg::hgt_req_t                  hgt_req;
    logic [vcsh_pkg::ID_W-1:0]           vox_rdata;
    logic [vcsh_pkg::HW-1:0]             hgt_rdata;

    logic                                s_beat;
    logic                                is_write;
    logic                                cell_air;
    logic [vcsh_pkg::COL_AW-1:0]         clr_col;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign is_write = (cmd_reg == vcsh_pkg::CMD_WRITE) && inside_reg;
    assign cell_air = (vox_rdata == '0);
    assign clr_col  = clr_cnt_reg[vcsh_pkg::COL_AW-1:0];

    // The scan walks the column at height t; the face test steps around y
    assign nbr_y    = (state_reg == ST_SCAN_RD) ? t_reg : y_reg;
    assign nbr_step = (state_reg == ST_FACE && int'(k_reg) < FACE_LAST)
                    ? vcsh_pkg::step_t'(k_reg) : vcsh_pkg::STEP_SELF;

    vcsh_nbr_unit u_nbr (
        .x      (x_reg),
        .y      (nbr_y),
        .z      (z_reg),
        .border (border_reg),
        .step   (nbr_step),
        .nbr    (nbr)
    );

    vcsh_store u_store (
        .aclk      (aclk),
        .vox_req   (vox_req),
        .vox_rdata (vox_rdata),
        .hgt_req   (hgt_req),
        .hgt_rdata (hgt_rdata)
    );

    // ------------------------------------------------------------------
    // Memory requests
    // ------------------------------------------------------------------
    always_comb begin
        vox_req.we    = 1'b0;
        vox_req.addr  = nbr.addr;
        vox_req.wdata = id_reg;
        hgt_req.we    = 1'b0;
        hgt_req.addr  = vcsh_pkg::col_addr(x_reg, z_reg);
        hgt_req.wdata = hgt_next;
        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep voxels to air; the low address bits cover every column
                vox_req.we    = 1'b1;
                vox_req.addr  = clr_cnt_reg;
                vox_req.wdata = '0;
                hgt_req.we    = (int'(clr_col) < vcsh_pkg::COLS);
                hgt_req.addr  = clr_col;
                hgt_req.wdata = '0;
            end
            ST_HUSE: begin
                vox_req.we = is_write;
                hgt_req.we = is_write && (id_reg != '0)
                          && (int'(y_reg) > int'(hgt_rdata));
            end
            ST_SCAN_RD: begin
                hgt_req.we = (t_reg == '0);
            end
            ST_SCAN_USE: begin
                hgt_req.we = !cell_air;
            end
            default: begin
                vox_req.we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        id_next        = id_reg;
        border_next    = border_reg;
        inside_next    = inside_reg;
        changed_next   = changed_reg;
        hgt_next       = hgt_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        prev_step_next = nbr_step;
        prev_frc_next  = nbr.forced;
        prev_fval_next = nbr.fval;
        cell_next      = cell_reg;
        mask_next      = mask_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == vcsh_pkg::VOX_AW'(vcsh_pkg::CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_beat) begin
                    cmd_next    = vcsh_pkg::cmd_t'(s_tuser);
                    x_next      = s_tdata[3:0];
                    y_next      = s_tdata[7:4];
                    z_next      = s_tdata[11:8];
                    id_next     = s_tdata[19:12];
                    border_next = s_tdata[23:20];
                    inside_next = (int'(s_tdata[3:0]) < vcsh_pkg::SIDE)
                               && (int'(s_tdata[7:4]) < vcsh_pkg::HEIGHT)
                               && (int'(s_tdata[11:8]) < vcsh_pkg::SIDE);
                    if (vcsh_pkg::cmd_t'(s_tuser) == vcsh_pkg::CMD_CLEAR) begin
                        changed_next = 1'b0;
                    end
                    if (inside_next) begin
                        state_next = ST_HREAD;
                    end else begin
                        // Off-grid position: answer zero cell, height and faces, leave the store alone
                        cell_next  = '0;
                        hgt_next   = '0;
                        mask_next  = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HREAD: begin
                state_next = ST_HUSE;
            end
            ST_HUSE: begin
                hgt_next   = hgt_rdata;
                k_next     = '0;
                state_next = ST_FACE;
                if (is_write) begin
                    changed_next = 1'b1;
                    if (id_reg != '0 && int'(y_reg) > int'(hgt_rdata)) begin
                        // Solid block above the top: raise the height
                        hgt_next = vcsh_pkg::HW'(y_reg);
                    end else if (id_reg == '0 && int'(y_reg) == int'(hgt_rdata)) begin
                        // Top cell removed: scan down for the next solid cell
                        t_next     = y_reg;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (t_reg == '0) begin
                    hgt_next   = '0;
                    k_next     = '0;
                    state_next = ST_FACE;
                end else begin
                    state_next = ST_SCAN_USE;
                end
            end
            ST_SCAN_USE: begin
                if (cell_air) begin
                    t_next     = t_reg - 1'b1;
                    state_next = ST_SCAN_RD;
                end else begin
                    hgt_next   = vcsh_pkg::HW'(t_reg);
                    k_next     = '0;
                    state_next = ST_FACE;
                end
            end
            ST_FACE: begin
                k_next = k_reg + 1'b1;
                // Read data of the previous step lands this cycle
                if (k_reg != '0) begin
                    case (prev_step_reg)
                        vcsh_pkg::STEP_SELF:  cell_next = vox_rdata;
                        vcsh_pkg::STEP_UP:    mask_next[0] = prev_frc_reg ? prev_fval_reg : cell_air;
                        vcsh_pkg::STEP_DOWN:  mask_next[1] = prev_frc_reg ? prev_fval_reg : cell_air;
                        vcsh_pkg::STEP_LEFT:  mask_next[2] = prev_frc_reg ? prev_fval_reg : cell_air;
                        vcsh_pkg::STEP_RIGHT: mask_next[3] = prev_frc_reg ? prev_fval_reg : cell_air;
                        vcsh_pkg::STEP_FRONT: mask_next[4] = prev_frc_reg ? prev_fval_reg : cell_air;
                        vcsh_pkg::STEP_BACK:  mask_next[5] = prev_frc_reg ? prev_fval_reg : cell_air;
                        default:              cell_next = cell_reg;
                    endcase
                end
                if (int'(k_reg) == FACE_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = vcsh_pkg::M_TDATA_W'({changed_reg, mask_reg,
                                        vcsh_pkg::OUT_HGT_W'(hgt_reg), cell_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            changed_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            changed_reg  <= changed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        id_reg        <= id_next;
        border_reg    <= border_next;
        inside_reg    <= inside_next;
        hgt_reg       <= hgt_next;
        t_reg         <= t_next;
        k_reg         <= k_next;
        prev_step_reg <= prev_step_next;
        prev_frc_reg  <= prev_frc_next;
        prev_fval_reg <= prev_fval_next;
        cell_reg      <= cell_next;
        mask_reg      <= mask_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule
`default_nettype wire

@@ tb/sv/voxel_view_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel view checker
// Watches the command and result channels of the voxel chunk store, keeps a
// shadow grid, column tops and changed flag, and checks every result beat
// against the view predicted for the oldest outstanding command beat.
// ----------------------------------------------------------------------------
module voxel_view_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // tdata: pos_x, pos_y, pos_z, block_id, border_open
    input  logic [vcsh_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: cmd
    input  logic [1:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: cell_value, column_height, face_mask, changed, zero fill
    input  logic [vcsh_pkg::M_TDATA_W-1:0]     m_tdata,
    output int                                 mismatch_count,
    output int                                 views_pending
);
    import vcsh_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]      cell_value;
        logic [OUT_HGT_W-1:0] column_height;
        logic [MASK_W-1:0]    face_mask;
        logic                 changed;
    } cell_view_t;

    logic [ID_W-1:0] shadow_grid [CELLS];
    logic [HW-1:0]   shadow_top  [COLS];
    logic            shadow_dirty;
    cell_view_t      view_queue [$];
    cell_view_t      want_view;
    cell_view_t      got_view;

    function automatic int vox_index(input int x, input int y, input int z);
        return (x * HEIGHT + y) * SIDE + z;
    endfunction

    function automatic logic is_air(input int x, input int y, input int z);
        return shadow_grid[vox_index(x, y, z)] == '0;
    endfunction

    // Apply one command to the shadow state and return the view of its cell
    function automatic cell_view_t predict_view(
        input cmd_t            cmd,
        input int              x,
        input int              y,
        input int              z,
        input logic [ID_W-1:0] id,
        input logic [3:0]      border
    );
        cell_view_t       v;
        int               col;
        int               h;
        int               t;
        logic [MASK_W-1:0] m;
        col = x * SIDE + z;
        if (cmd == CMD_WRITE) begin
            h = int'(shadow_top[col]);
            shadow_grid[vox_index(x, y, z)] = id;
            shadow_dirty = 1'b1;
            if (y > h && id != '0) begin
                shadow_top[col] = HW'(y);
                h = y;
            end
            // Removing the column top: walk down to the next solid cell
            if (y == h && id == '0) begin
                t = y;
                while (t > 0 && is_air(x, t, z))
                    t--;
                shadow_top[col] = HW'(t);
            end
        end else if (cmd == CMD_CLEAR) begin
            shadow_dirty = 1'b0;
        end
        m[0] = (y == TOP_Y) ? 1'b1 : is_air(x, y + 1, z);
        m[1] = (y == 0)     ? 1'b1 : is_air(x, y - 1, z);
        m[2] = (x == 0)     ? border[0] : is_air(x - 1, y, z);
        m[3] = (x == EDGE)  ? border[1] : is_air(x + 1, y, z);
        m[4] = (z == 0)     ? border[2] : is_air(x, y, z - 1);
        m[5] = (z == EDGE)  ? border[3] : is_air(x, y, z + 1);
        v.cell_value    = shadow_grid[vox_index(x, y, z)];
        v.column_height = OUT_HGT_W'(shadow_top[col]);
        v.face_mask     = m;
        v.changed       = shadow_dirty;
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (shadow_grid[i]) shadow_grid[i] = '0;
            foreach (shadow_top[i]) shadow_top[i] = '0;
            shadow_dirty = 1'b0;
            view_queue.delete();
            mismatch_count = 0;
        end else begin
            // Check the result side first: a beat leaving now never belongs
            // to a command accepted at the same edge
            if (m_tvalid && m_tready) begin
                got_view.cell_value    = m_tdata[7:0];
                got_view.column_height = m_tdata[11:8];
                got_view.face_mask     = m_tdata[17:12];
                got_view.changed       = m_tdata[18];
                if (view_queue.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result beat with nothing outstanding: %h",
                                 $realtime, m_tdata);
                    mismatch_count++;
                end else begin
                    want_view = view_queue.pop_front();
                    if (got_view.cell_value !== want_view.cell_value ||
                        got_view.column_height !== want_view.column_height ||
                        got_view.face_mask !== want_view.face_mask ||
                        got_view.changed !== want_view.changed) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: view mismatch", $realtime);
                            $display("  expected id %h height %h faces %b changed %b",
                                     want_view.cell_value, want_view.column_height,
                                     want_view.face_mask, want_view.changed);
                            $display("  actual   id %h height %h faces %b changed %b",
                                     got_view.cell_value, got_view.column_height,
                                     got_view.face_mask, got_view.changed);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                view_queue.push_back(predict_view(cmd_t'(s_tuser),
                                                  int'(s_tdata[3:0]),
                                                  int'(s_tdata[7:4]),
                                                  int'(s_tdata[11:8]),
                                                  s_tdata[19:12],
                                                  s_tdata[23:20]));
        end
        views_pending = view_queue.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel chunk store testbench
// Drives directed and random command beats into the chunk store, stalls both
// channels in random bursts, and leaves prediction and checking to the view
// checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import vcsh_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int QUIET_ITEMS = 150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 64;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int idle_pct;
    int sent;
    int cycles;

    voxel_chunk_store_heightmap_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    voxel_view_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatches),
        .views_pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: the clearing sweep plus the slowest items fit many times over
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: drop tready in random bursts while idling is on
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_tready = 1'b1;
            end
        end
    end

    // Favor a small central patch so neighbors are often solid; keep edges
    // common so the border bits matter
    function automatic logic [3:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom_range(0, 1) ? 4'd15 : 4'd0;
        else if (r < 5)
            return 4'($urandom_range(0, 15));
        else
            return 4'($urandom_range(6, 9));
    endfunction

    // Send one command beat; called and returning at a falling edge. Valid
    // stays high after the accept unless the next call opens a gap.
    task automatic issue_cmd(
        input cmd_t       cmd,
        input logic [3:0] x,
        input logic [3:0] y,
        input logic [3:0] z,
        input logic [7:0] id,
        input logic [3:0] border
    );
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tdata  = {border, id, z, y, x};
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        sent++;
        @(negedge aclk);
    endtask

    // Hold the sender until every outstanding view has come back
    task automatic drain_views();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Stack blocks upward in one column, with some air gaps
    task automatic build_column();
        logic [3:0] x;
        logic [3:0] z;
        int         y0;
        int         n;
        logic [7:0] id;
        x  = pick_coord();
        z  = pick_coord();
        y0 = $urandom_range(0, 12);
        n  = $urandom_range(1, 8);
        for (int i = 0; i < n && y0 + i <= TOP_Y; i++) begin
            id = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            issue_cmd(CMD_WRITE, x, 4'(y0 + i), z, id, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0)
                issue_cmd(CMD_QUERY, x, 4'(y0 + i), z, 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)));
        end
    endtask

    // Clear a column from high to low so writes land on the recorded top
    task automatic dig_column();
        logic [3:0] x;
        logic [3:0] z;
        int         y_hi;
        int         y_lo;
        x    = pick_coord();
        z    = pick_coord();
        y_hi = $urandom_range(6, 15);
        y_lo = $urandom_range(0, y_hi);
        for (int y = y_hi; y >= y_lo; y--) begin
            issue_cmd(CMD_WRITE, x, 4'(y), z, 8'd0, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 4) == 0)
                issue_cmd(CMD_QUERY, x, 4'(y), z, 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)));
        end
    endtask

    // Look around the patch with random border bits
    task automatic probe_area();
        int   n;
        cmd_t cmd;
        n = $urandom_range(2, 6);
        repeat (n) begin
            cmd = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_QUERY;
            issue_cmd(cmd, pick_coord(), 4'($urandom_range(0, 15)), pick_coord(),
                      8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        int  next_phase;
        bit  mid_pause_done;
        int  kind;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_QUERY;
        idle_pct = 0;
        sent     = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty grid at the corners, with all and no borders open
        issue_cmd(CMD_QUERY, 4'd0, 4'd0, 4'd0, 8'd0, 4'h0);
        issue_cmd(CMD_QUERY, 4'd0, 4'd0, 4'd0, 8'd0, 4'hF);
        issue_cmd(CMD_QUERY, 4'd15, 4'd15, 4'd15, 8'hFF, 4'hF);
        issue_cmd(CMD_QUERY, 4'd15, 4'd15, 4'd15, 8'hFF, 4'h0);
        // Floor block leaves the height at zero; top block raises it to 15
        issue_cmd(CMD_WRITE, 4'd7, 4'd0, 4'd7, 8'hFF, 4'h5);
        issue_cmd(CMD_WRITE, 4'd7, 4'd15, 4'd7, 8'h01, 4'hA);
        // Solid below the top: no raise
        issue_cmd(CMD_WRITE, 4'd7, 4'd5, 4'd7, 8'h80, 4'h0);
        // Remove the top: scan down to the block at 5
        issue_cmd(CMD_WRITE, 4'd7, 4'd15, 4'd7, 8'h00, 4'h0);
        // Air below the top: no scan
        issue_cmd(CMD_WRITE, 4'd7, 4'd4, 4'd7, 8'h00, 4'hF);
        // Remove the top again: scan reaches the floor
        issue_cmd(CMD_WRITE, 4'd7, 4'd5, 4'd7, 8'h00, 4'h0);
        // Remove at height zero
        issue_cmd(CMD_WRITE, 4'd7, 4'd0, 4'd7, 8'h00, 4'h0);
        // Overwrite, then enclose a cell on all six sides
        issue_cmd(CMD_WRITE, 4'd8, 4'd3, 4'd8, 8'h55, 4'h0);
        issue_cmd(CMD_WRITE, 4'd8, 4'd3, 4'd8, 8'hAA, 4'h0);
        issue_cmd(CMD_WRITE, 4'd7, 4'd3, 4'd8, 8'h11, 4'h0);
        issue_cmd(CMD_WRITE, 4'd9, 4'd3, 4'd8, 8'h22, 4'h0);
        issue_cmd(CMD_WRITE, 4'd8, 4'd3, 4'd7, 8'h33, 4'h0);
        issue_cmd(CMD_WRITE, 4'd8, 4'd3, 4'd9, 8'h44, 4'h0);
        issue_cmd(CMD_WRITE, 4'd8, 4'd4, 4'd8, 8'h66, 4'h0);
        issue_cmd(CMD_WRITE, 4'd8, 4'd2, 4'd8, 8'h77, 4'h0);
        issue_cmd(CMD_QUERY, 4'd8, 4'd3, 4'd8, 8'h00, 4'hF);
        // Clear the flag; the spare code answers as a query
        issue_cmd(CMD_CLEAR, 4'd8, 4'd3, 4'd8, 8'h00, 4'h0);
        issue_cmd(CMD_SPARE, 4'd8, 4'd4, 4'd8, 8'hFF, 4'hF);
        // Mixed borders at an x-high, z-low corner, then a top-edge block
        issue_cmd(CMD_QUERY, 4'd15, 4'd0, 4'd0, 8'h00, 4'hA);
        issue_cmd(CMD_WRITE, 4'd0, 4'd15, 4'd15, 8'h0F, 4'h5);
        issue_cmd(CMD_CLEAR, 4'd0, 4'd15, 4'd15, 8'h00, 4'hF);

        // Hold off until the pipe is empty once
        drain_views();

        next_phase     = sent;
        mid_pause_done = 1'b0;
        while (sent < ITEM_TARGET) begin
            if (sent >= ITEM_TARGET - QUIET_ITEMS) begin
                idle_pct = 0;
            end else if (sent >= next_phase) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 35;
                endcase
                next_phase = sent + 100;
            end
            if (!mid_pause_done && sent >= ITEM_TARGET / 2) begin
                drain_views();
                mid_pause_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 40)
                build_column();
            else if (kind < 65)
                dig_column();
            else if (kind < 90)
                probe_area();
            else
                issue_cmd(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        end

        // Wait out the outstanding views, then watch for stray beats
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ voxel_chunk_store_heightmap_core.f @@
sv/vcsh_pkg.sv
sv/vcsh_nbr_unit.sv
sv/vcsh_store.sv
sv/voxel_chunk_store_heightmap_core.sv
tb/sv/voxel_view_checker.sv
tb/sv/testbench.sv
